[hw/rtl/topological_sort_kahn_top_assert.svh]
// Assertion macros for the topological sort block
`ifndef TOPOLOGICAL_SORT_KAHN_TOP_ASSERT_SVH
`define TOPOLOGICAL_SORT_KAHN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TSK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TSK_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSK_ASSERT(label, clk, rst, prop, msg)
`define TSK_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hw/rtl/tsk_pkg.sv]
`default_nettype none
package tsk_pkg;
   localparam int MaxNodes = 64;
   localparam int MaxEdges = 256;
   localparam int NodeW    = $clog2(MaxNodes);
   localparam int EdgeW    = $clog2(MaxEdges);
   localparam int CntW     = $clog2(MaxNodes + 1);
   localparam int TotW     = $clog2(MaxEdges + 1);
   localparam int DegW     = TotW;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusCycle = 2'd1;
   localparam logic [1:0] StatusBad   = 2'd2;

   // steps within one walk entry
   localparam logic [1:0] StepAddr = 2'd0;   // store read issued
   localparam logic [1:0] StepDeg  = 2'd1;   // degree read issued
   localparam logic [1:0] StepUpd  = 2'd2;   // degree update

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_LOAD = 2'd1,
      OP_RUN  = 2'd2
   } op_type;

   // phase of the datapath, driven by controller
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_CHECK = 4'd1,   // walk edges, validate and count in-degree
      PH_CLEAR = 4'd2,   // zero degree table
      PH_SEED  = 4'd3,   // enqueue zero in-degree nodes
      PH_POP   = 4'd4,   // pop queue head
      PH_SCAN  = 4'd5,   // walk edges for popped node
      PH_EMIT  = 4'd6,
      PH_DONE  = 4'd7
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       start;   // first cycle of phase: reset counters
      logic       load;    // store one edge
      logic       clear;   // clear store after run
   } cmd_type;

   typedef struct packed {
      logic walk_done;     // edge / node walk finished
      logic queue_empty;
      logic bad;
      logic complete;      // every node ordered
      logic emit_done;
   } sts_type;
endpackage
`default_nettype wire

[hw/rtl/tsk_datapath.sv]
`default_nettype none
module tsk_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tsk_pkg::cmd_type       cmd,
   input  wire logic [6:0]             node_count,
   input  wire logic [tsk_pkg::NodeW-1:0] load_from,
   input  wire logic [tsk_pkg::NodeW-1:0] load_to,
   input  wire logic                   out_take,
   output tsk_pkg::sts_type            sts,
   output logic [tsk_pkg::NodeW-1:0]   out_node,
   output logic                        out_last
);
   import tsk_pkg::*;

   logic [NodeW-1:0] src_mem [MaxEdges];
   logic [NodeW-1:0] dst_mem [MaxEdges];
   logic [DegW-1:0]  deg_mem [MaxNodes];
   logic [NodeW-1:0] que_mem [MaxNodes];

   logic [TotW-1:0]  total_ff, total_in;
   logic             err_ff, err_in;
   logic [TotW-1:0]  idx_ff, idx_in;     // edge or node walk index
   logic [1:0]       sub_ff, sub_in;     // step within one entry
   logic [CntW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [NodeW-1:0] u_ff, u_in;
   logic [CntW-1:0]  nact;
   logic             load_ok;

   // registered read data of the stores
   logic [NodeW-1:0] src_rd_ff, dst_rd_ff, que_rd_ff;
   logic [DegW-1:0]  deg_rd_ff;

   logic [NodeW-1:0] nidx, deg_addr, que_addr, deg_waddr;
   logic [DegW-1:0]  deg_wdata;
   logic             deg_we;
   logic             e_live, node_live;
   logic             seed_hit, scan_hit;

   // effective node count
   always_comb begin
      if (node_count == 7'd0) nact = CntW'(1);
      else if (node_count > 7'(MaxNodes)) nact = CntW'(MaxNodes);
      else nact = CntW'(node_count);
   end

   assign load_ok = ({1'b0, load_from} < nact) && ({1'b0, load_to} < nact)
                    && (total_ff < TotW'(MaxEdges));

   assign e_live    = idx_ff < total_ff;
   assign node_live = idx_ff < TotW'(nact);
   assign nidx      = idx_ff[NodeW-1:0];
   assign deg_addr  = (cmd.phase == PH_SEED) ? nidx : dst_rd_ff;
   // emit reads ahead so the word is ready when idx moves
   assign que_addr  = (cmd.phase == PH_EMIT) ? idx_in[NodeW-1:0] : head_ff[NodeW-1:0];

   assign seed_hit = cmd.phase == PH_SEED && !cmd.start && sub_ff == StepDeg
                     && deg_rd_ff == '0;
   assign scan_hit = cmd.phase == PH_SCAN && !cmd.start && sub_ff == StepUpd
                     && src_rd_ff == u_ff && deg_rd_ff == DegW'(1)
                     && tail_ff < CntW'(MaxNodes);

   always_comb begin
      deg_we    = 1'b0;
      deg_waddr = dst_rd_ff;
      deg_wdata = deg_rd_ff + DegW'(1);
      if (!cmd.start) begin
         unique case (cmd.phase)
            PH_CLEAR: begin
               deg_we    = node_live;
               deg_waddr = nidx;
               deg_wdata = '0;
            end
            PH_CHECK: deg_we = sub_ff == StepUpd;
            PH_SCAN: begin
               deg_we    = sub_ff == StepUpd && src_rd_ff == u_ff && deg_rd_ff != '0;
               deg_wdata = deg_rd_ff - DegW'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         src_mem[total_ff[EdgeW-1:0]] <= load_from;
         dst_mem[total_ff[EdgeW-1:0]] <= load_to;
      end
      src_rd_ff <= src_mem[idx_ff[EdgeW-1:0]];
      dst_rd_ff <= dst_mem[idx_ff[EdgeW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
      deg_rd_ff <= deg_mem[deg_addr];
   end

   always_ff @(posedge clock) begin
      if (seed_hit) que_mem[tail_ff[NodeW-1:0]] <= nidx;
      else if (scan_hit) que_mem[tail_ff[NodeW-1:0]] <= dst_rd_ff;
      que_rd_ff <= que_mem[que_addr];
   end

   always_comb begin
      total_in = total_ff;
      err_in   = err_ff;
      idx_in   = idx_ff;
      sub_in   = sub_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      u_in     = u_ff;
      if (cmd.load) begin
         if (load_ok) total_in = total_ff + TotW'(1);
         else err_in = 1'b1;
      end
      if (cmd.start) begin
         idx_in = '0;
         sub_in = StepAddr;
      end else begin
         unique case (cmd.phase)
            PH_CHECK, PH_SCAN: if (e_live) begin
               if (sub_ff == StepUpd) begin
                  idx_in = idx_ff + TotW'(1);
                  sub_in = StepAddr;
               end else begin
                  sub_in = (sub_ff == StepAddr) ? StepDeg : StepUpd;
               end
               if (cmd.phase == PH_CHECK && sub_ff == StepUpd
                   && ({1'b0, src_rd_ff} >= nact || {1'b0, dst_rd_ff} >= nact))
                  err_in = 1'b1;
            end
            PH_CLEAR: if (node_live) idx_in = idx_ff + TotW'(1);
            PH_SEED: if (node_live) begin
               if (sub_ff == StepDeg) begin
                  idx_in = idx_ff + TotW'(1);
                  sub_in = StepAddr;
               end else begin
                  sub_in = StepDeg;
               end
            end
            PH_EMIT: if (out_take) idx_in = idx_ff + TotW'(1);
            default: ;
         endcase
      end
      if (cmd.phase == PH_CLEAR && cmd.start) begin
         head_in = '0;
         tail_in = '0;
      end
      if (seed_hit || scan_hit) tail_in = tail_ff + CntW'(1);
      if (cmd.phase == PH_POP) head_in = head_ff + CntW'(1);
      // popped node arrives from the registered queue read in the cycle after the pop
      if (cmd.phase == PH_SCAN && cmd.start) u_in = que_rd_ff;
      if (cmd.clear) begin
         total_in = '0;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         err_ff   <= 1'b0;
         idx_ff   <= '0;
         sub_ff   <= StepAddr;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         total_ff <= total_in;
         err_ff   <= err_in;
         idx_ff   <= idx_in;
         sub_ff   <= sub_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      u_ff <= u_in;
   end

   always_comb begin
      sts.walk_done = 1'b0;
      unique case (cmd.phase)
         PH_CHECK, PH_SCAN: sts.walk_done = !e_live;
         PH_CLEAR, PH_SEED: sts.walk_done = !node_live;
         default: sts.walk_done = 1'b0;
      endcase
      sts.queue_empty = head_ff >= tail_ff;
      sts.bad         = err_ff;
      sts.complete    = head_ff == nact;
      sts.emit_done   = out_take && idx_ff + TotW'(1) >= TotW'(nact);
   end

   assign out_node = que_rd_ff;
   assign out_last = idx_ff + TotW'(1) >= TotW'(nact);

   `include "topological_sort_kahn_top_assert.svh"
   `TSK_ASSERT(a_head_le_tail, clock, reset, head_ff <= tail_ff, "queue head passed tail")
   `TSK_ASSERT(a_tail_max, clock, reset, tail_ff <= CntW'(MaxNodes), "queue overrun")
   `TSK_ASSERT(a_total_max, clock, reset, total_ff <= TotW'(MaxEdges), "edge count overrun")
endmodule
`default_nettype wire

[hw/rtl/tsk_ctrl.sv]
`default_nettype none
module tsk_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_action,
   output logic                  req_stall,
   input  wire tsk_pkg::sts_type sts,
   output tsk_pkg::cmd_type      cmd,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_final,   // single status word
   output logic [1:0]            rsp_code
);
   import tsk_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CHECK = 8'b0000_0010,
      S_CLEAR = 8'b0000_0100,
      S_SEED  = 8'b0000_1000,
      S_POP   = 8'b0001_0000,
      S_SCAN  = 8'b0010_0000,
      S_EMIT  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      start_ff, start_in;
   logic [1:0] code_ff, code_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      start_in = 1'b0;
      code_in  = code_ff;
      cmd      = '{phase: PH_IDLE, start: start_ff, load: 1'b0, clear: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_action) cmd.load = 1'b1;
            if (req_valid && req_action) begin
               state_in = S_CLEAR;
               start_in = 1'b1;
            end
         end
         S_CLEAR: begin
            cmd.phase = PH_CLEAR;
            if (!start_ff && sts.walk_done) begin
               state_in = S_CHECK;
               start_in = 1'b1;
            end
         end
         S_CHECK: begin
            cmd.phase = PH_CHECK;
            if (!start_ff && sts.walk_done) begin
               state_in = sts.bad ? S_DONE : S_SEED;
               code_in  = StatusBad;
               start_in = 1'b1;
            end
         end
         S_SEED: begin
            cmd.phase = PH_SEED;
            if (!start_ff && sts.walk_done) state_in = S_POP;
         end
         S_POP: begin
            if (sts.queue_empty) begin
               if (sts.complete) begin
                  state_in = S_EMIT;
                  start_in = 1'b1;
               end else begin
                  state_in = S_DONE;
                  code_in  = StatusCycle;
               end
            end else begin
               cmd.phase = PH_POP;
               state_in  = S_SCAN;
               start_in  = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.phase = PH_SCAN;
            if (!start_ff && sts.walk_done) state_in = S_POP;
         end
         S_EMIT: begin
            cmd.phase = PH_EMIT;
            if (!start_ff && sts.emit_done) begin
               state_in  = S_IDLE;
               cmd.clear = 1'b1;
            end
         end
         S_DONE: begin
            cmd.phase = PH_DONE;
            if (!rsp_stall) begin
               state_in  = S_IDLE;
               cmd.clear = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == S_DONE) || (state_ff == S_EMIT && !start_ff);
   assign rsp_final = state_ff == S_DONE;
   assign rsp_code  = code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
         code_ff  <= StatusOk;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         code_ff  <= code_in;
      end
   end

   `include "topological_sort_kahn_top_assert.svh"
   `TSK_ASSERT(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `TSK_ASSERT(a_stall_busy, clock, reset, rsp_valid |-> req_stall, "input open during output")
   `TSK_ASSERT(a_done_code, clock, reset, rsp_final |-> (rsp_code != StatusOk),
      "status word with ok code")
endmodule
`default_nettype wire

[hw/rtl/topological_sort_kahn_top.sv]
`default_nettype none
// Kahn topological sort engine.
// Request channel (req_valid/req_stall): req_action 0 loads one edge
// req_from_node -> req_to_node into the edge store, one word per cycle while
// idle and no response. req_action 1 runs the sort; req_stall stays high
// until the last response word of that run is taken.
// Response channel (rsp_valid/rsp_stall): either node_count words of status
// ok in topological order, rsp_last on the final one, or a single word with
// status cycle (1) or bad edge (2), node 0, last 1.
// csr_write loads node_count (0 acts as 1, above 64 acts as 64); write only
// while idle.
// A run clears the degree table, then validates each stored edge and counts
// in-degree (per edge: store read, degree read, degree update), then seeds
// the queue with zero in-degree nodes, then pops each node and scans the
// store for its edges; the ok words then follow at one word per cycle
// while the receiver does not stall. A bad edge answers once validation
// ends, with no seeding or scan.
// A stall holds the current word; the walk is already finished by then.
// Synchronous reset empties the edge store, clears the error flag and sets
// node_count to 64. The store is emptied after every run.
module topological_sort_kahn_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_action,
   input  wire logic [5:0] req_from_node,
   input  wire logic [5:0] req_to_node,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [5:0]      rsp_node,
   output logic            rsp_last,
   output logic [1:0]      rsp_status,
   input  wire logic       csr_write,
   input  wire logic [6:0] csr_wdata
);
   import tsk_pkg::*;

   cmd_type         cmd;
   sts_type         sts;
   logic [6:0]      ncount_ff;
   logic            rsp_final;
   logic [1:0]      rsp_code;
   logic [NodeW-1:0] dp_node;
   logic            dp_last;

   always_ff @(posedge clock) begin
      if (reset) ncount_ff <= 7'(MaxNodes);
      else if (csr_write) ncount_ff <= csr_wdata;
   end

   tsk_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_action, .req_stall,
      .sts, .cmd, .rsp_valid, .rsp_stall, .rsp_final, .rsp_code
   );

   tsk_datapath u_dp (
      .clock, .reset, .cmd,
      .node_count (ncount_ff),
      .load_from  (req_from_node),
      .load_to    (req_to_node),
      .out_take   (rsp_valid && !rsp_stall && !rsp_final),
      .sts,
      .out_node   (dp_node),
      .out_last   (dp_last)
   );

   // status word wins over the order stream
   assign rsp_node   = rsp_final ? '0 : dp_node;
   assign rsp_last   = rsp_final ? 1'b1 : dp_last;
   assign rsp_status = rsp_final ? rsp_code : StatusOk;
endmodule
`default_nettype wire

[tb/topological_sort_kahn_top_test.sv]
`default_nettype none
module topological_sort_kahn_top_test;
   import tsk_pkg::*;

   typedef struct {
      logic [5:0] node;
      logic       last;
      logic [1:0] status;
   } order_word_type;

   // Order predictor and the queue of words still owed by the block.
   class scoreboard_type;
      logic [5:0]     edge_src[$];
      logic [5:0]     edge_dst[$];
      logic           edge_bad;
      logic [6:0]     node_count;
      order_word_type owed[$];
      int             errors;
      int             checked;
      int             runs;

      function new();
         edge_bad   = 1'b0;
         node_count = 7'd64;
         errors     = 0;
         checked    = 0;
         runs       = 0;
      endfunction

      task report(string what);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      function void set_count(logic [6:0] value);
         node_count = value;
      endfunction

      function int active_count();
         if (node_count == 0) return 1;
         if (node_count > MaxNodes) return MaxNodes;
         return node_count;
      endfunction

      function void owe(logic [5:0] node, logic last, logic [1:0] status);
         order_word_type w;
         w.node   = node;
         w.last   = last;
         w.status = status;
         owed = {owed, w};
      endfunction

      function void note_input(logic act, logic [5:0] from_n, logic [5:0] to_n);
         int n, head, tail, u;
         int deg[MaxNodes];
         logic [5:0] ready[MaxNodes];
         n = active_count();
         if (!act) begin
            if (from_n >= n || to_n >= n || edge_src.size() >= MaxEdges)
               edge_bad = 1'b1;
            else begin
               edge_src = {edge_src, from_n};
               edge_dst = {edge_dst, to_n};
            end
            return;
         end
         runs++;
         // edges stored under a larger node count go bad when it shrinks
         foreach (edge_src[e])
            if (edge_src[e] >= n || edge_dst[e] >= n) edge_bad = 1'b1;
         if (edge_bad) begin
            owe(6'd0, 1'b1, StatusBad);
         end else begin
            for (int i = 0; i < MaxNodes; i++) deg[i] = 0;
            foreach (edge_dst[e]) deg[edge_dst[e]]++;
            tail = 0;
            for (int i = 0; i < n; i++)
               if (deg[i] == 0) begin
                  ready[tail] = 6'(i);
                  tail++;
               end
            head = 0;
            while (head < tail) begin
               u = ready[head];
               head++;
               foreach (edge_src[e])
                  if (edge_src[e] == u && deg[edge_dst[e]] > 0) begin
                     deg[edge_dst[e]]--;
                     if (deg[edge_dst[e]] == 0 && tail < MaxNodes) begin
                        ready[tail] = edge_dst[e];
                        tail++;
                     end
                  end
            end
            if (head != n) owe(6'd0, 1'b1, StatusCycle);
            else
               for (int i = 0; i < n; i++) owe(ready[i], i == n - 1, StatusOk);
         end
         edge_src.delete();
         edge_dst.delete();
         edge_bad = 1'b0;
      endfunction

      task check_result(logic [5:0] node, logic last, logic [1:0] status);
         order_word_type w;
         checked++;
         if (owed.size() == 0) begin
            report($sformatf("unexpected word node %0d last %0d status %0d",
                             node, last, status));
            return;
         end
         w = owed.pop_front();
         if (node !== w.node)
            report($sformatf("node %0d, want %0d", node, w.node));
         if (last !== w.last)
            report($sformatf("last %0d, want %0d", last, w.last));
         if (status !== w.status)
            report($sformatf("status %0d, want %0d", status, w.status));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_action;
   logic [5:0] req_from_node;
   logic [5:0] req_to_node;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [5:0] rsp_node;
   logic       rsp_last;
   logic [1:0] rsp_status;
   logic       csr_write;
   logic [6:0] csr_wdata;

   scoreboard_type sb;
   bit  no_gaps;        // back-to-back stretch on both sides
   int  hold_cycles;    // long receiver hold-off, consumed by receiver
   int  sent_items;

   topological_sort_kahn_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_from_node (req_from_node),
      .req_to_node   (req_to_node),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_node      (rsp_node),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .csr_write     (csr_write),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run cap: far beyond the slowest legal run.
   initial begin
      #50000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one word; returns once it has been taken.
   task automatic send_word(logic act, logic [5:0] from_n, logic [5:0] to_n);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_from_node <= from_n;
      req_to_node   <= to_n;
      do @(posedge clock); while (req_stall);
      sb.note_input(act, from_n, to_n);
      sent_items++;
   endtask

   task automatic add_edge(int from_n, int to_n);
      send_word(1'b0, 6'(from_n), 6'(to_n));
   endtask

   task automatic run_sort();
      // from/to are don't-care on a run; drive noise
      send_word(1'b1, 6'($urandom), 6'($urandom));
   endtask

   // Drop valid, wait for all owed words, let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_count(int value);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= 7'(value);
      @(posedge clock);
      sb.set_count(7'(value));
      csr_write <= 1'b0;
   endtask

   // Receiver: checks taken words, draws a stall stretch per word.
   initial begin : receiver
      int wait_left;
      wait_left = 0;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_node, rsp_last, rsp_status);
            wait_left = no_gaps ? 0 : $urandom_range(0, 15);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // One random phase: node count, then a graph, then a run.
   task automatic random_phase();
      int n, cfg, edges, kind, i, j, t, bad_at;
      int perm[MaxNodes];
      cfg = $urandom_range(0, 9);
      if (cfg == 0) cfg = $urandom_range(65, 127);          // clamps to 64
      else if (cfg == 1) cfg = 64;
      else if (cfg == 2) cfg = $urandom_range(0, 1);
      else cfg = $urandom_range(2, 12);
      write_count(cfg);
      n = sb.active_count();
      edges = (n < 2) ? $urandom_range(0, 2) : $urandom_range(0, 20);
      kind = $urandom_range(0, 9);
      for (i = 0; i < n; i++) perm[i] = i;
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      bad_at = (kind == 8 && n < 64) ? $urandom_range(0, edges) : -1;
      for (int e = 0; e < edges; e++) begin
         if (e == bad_at)
            add_edge($urandom_range(n, 63), $urandom_range(0, 63));
         else if (kind == 9 || n < 2)
            add_edge($urandom_range(0, 63), $urandom_range(0, 63));
         else begin
            i = $urandom_range(0, n - 2);
            j = $urandom_range(i + 1, n - 1);
            // one reversed edge can close a loop
            if (kind == 7 && e == edges - 1) add_edge(perm[j], perm[i]);
            else add_edge(perm[i], perm[j]);
         end
      end
      run_sort();
   endtask

   initial begin : stimulus
      sb = new();
      no_gaps       = 1'b0;
      hold_cycles   = 0;
      sent_items    = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_action    <= 1'b0;
      req_from_node <= 6'd0;
      req_to_node   <= 6'd0;
      csr_write     <= 1'b0;
      csr_wdata     <= 7'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty graph at reset count gives identity order.
      run_sort();
      // Count 0 acts as one node: self loop is a cycle, node 1 is bad.
      write_count(0);
      add_edge(0, 0);
      run_sort();
      add_edge(1, 0);
      run_sort();
      // Count above max clamps; top-index endpoints.
      write_count(127);
      add_edge(63, 62);
      add_edge(62, 0);
      add_edge(63, 0);
      run_sort();
      write_count(5);
      add_edge(4, 3);
      add_edge(3, 2);
      add_edge(2, 1);
      add_edge(1, 0);
      add_edge(63, 63);                 // bad endpoint, error sticks to run
      add_edge(0, 4);
      run_sort();
      // Count lowered after loading makes a stored edge bad.
      write_count(8);
      add_edge(7, 0);
      add_edge(1, 2);
      write_count(4);
      run_sort();
      // Duplicate edges, then a plain chain.
      write_count(3);
      add_edge(0, 1);
      add_edge(0, 1);
      add_edge(1, 2);
      run_sort();

      // Back-pressure: receiver holds off while the sender keeps going,
      // so a second run waits behind undelivered words.
      write_count(6);
      hold_cycles = 3000;
      add_edge(5, 4);
      run_sort();
      add_edge(2, 3);
      add_edge(3, 1);
      run_sort();

      // Random phases; a burst stretch now and then.
      while (sent_items < 230) begin
         no_gaps = ($urandom_range(0, 5) == 0);
         random_phase();
      end
      no_gaps = 1'b0;
      drain();

      if (sb.owed.size() != 0)
         sb.report($sformatf("%0d words never arrived", sb.owed.size()));
      $display("Covered %0d sort runs and %0d output words, node counts 0..127,",
               sb.runs, sb.checked);
      $display("cycles, bad edges, shrunk node counts and a long output hold-off.");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
